### src/ktl_pkg.sv
// ktl_pkg: shared widths, token kinds, lexer mode codes and byte classifiers
// for the keyword token lexer; used by the channel interfaces and the top level
// no dependencies
package ktl_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int KIND_W = 5;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 7;
  localparam int MODE_W = 3;
  localparam int PREFIX_BYTES = 5;
  localparam int PREFIX_W = PREFIX_BYTES * CHAR_W;

  // longest lexeme before the length sticks
  localparam int MAX_LEXEME = 127;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // lexer modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WORD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NUM  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EQ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BANG = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LT   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_GT   = 3'd6;

  // token kinds
  localparam logic [KIND_W-1:0] K_IF      = 5'd0;
  localparam logic [KIND_W-1:0] K_ELSE    = 5'd1;
  localparam logic [KIND_W-1:0] K_WHILE   = 5'd2;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd3;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd4;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd5;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd6;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd7;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd8;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd10;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd11;
  localparam logic [KIND_W-1:0] K_EQ      = 5'd12;
  localparam logic [KIND_W-1:0] K_NEQ     = 5'd13;
  localparam logic [KIND_W-1:0] K_LT      = 5'd14;
  localparam logic [KIND_W-1:0] K_GT      = 5'd15;
  localparam logic [KIND_W-1:0] K_LEQ     = 5'd16;
  localparam logic [KIND_W-1:0] K_GEQ     = 5'd17;
  localparam logic [KIND_W-1:0] K_NUMBER  = 5'd18;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd19;
  localparam logic [KIND_W-1:0] K_LTD     = 5'd20;
  localparam logic [KIND_W-1:0] K_END     = 5'd21;
  localparam logic [KIND_W-1:0] K_INVALID = 5'd22;

  // special bytes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;

  // keyword spellings, first byte in the low bits
  localparam logic [PREFIX_W-1:0] PACK_IF    = 40'h00_0000_6669;
  localparam logic [PREFIX_W-1:0] PACK_ELSE  = 40'h00_6573_6C65;
  localparam logic [PREFIX_W-1:0] PACK_WHILE = 40'h65_6C69_6877;
  localparam logic [PREFIX_W-1:0] PACK_LTD   = 40'h00_0044_544C;

  // one token on the result side
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic              sat;
    logic              last;
  } tok_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // mode a byte opens from idle, MODE_IDLE when it opens none
  function automatic logic [MODE_W-1:0] open_mode(input logic [CHAR_W-1:0] c);
    logic [MODE_W-1:0] m;
    m = MODE_IDLE;
    if (is_alpha(c))        m = MODE_WORD;
    else if (is_numeral(c)) m = MODE_NUM;
    else if (c == 8'h3D)    m = MODE_EQ;
    else if (c == 8'h21)    m = MODE_BANG;
    else if (c == 8'h3C)    m = MODE_LT;
    else if (c == 8'h3E)    m = MODE_GT;
    return m;
  endfunction

  // kind of a single-byte token
  function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3B:   k = K_SEMI;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

### src/ktl_if.sv
// ktl channel interfaces: byte input channel and token result channel
// depends on ktl_pkg for field widths
interface ktl_in_if;
  logic                        valid;
  logic                        ready;
  logic [ktl_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ktl_out_if;
  logic                        valid;
  logic                        ready;
  logic [ktl_pkg::KIND_W-1:0]  token_kind;
  logic [ktl_pkg::POS_W-1:0]   token_start;
  logic [ktl_pkg::LEN_W-1:0]   token_length;
  logic                        length_saturated;
  logic                        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output length_saturated,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input length_saturated,
                  input last_of_run, output ready);
endinterface

### src/keyword_token_lexer.sv
// keyword_token_lexer: streaming tokenizer, one text byte per transaction in,
// zero to two tokens per byte out through a four-entry result queue
// depends on ktl_pkg and the channel interfaces in ktl_if.sv
//
//  channel  | dir | payload                                    | accepted when
//  ---------+-----+--------------------------------------------+------------------
//  in_chan  | in  | char_code                                  | valid && ready
//  out_chan | out | token_kind, token_start, token_length,     | valid && ready
//           |     | length_saturated, last_of_run              |
//
// one byte is taken per cycle while two queue slots are free; its tokens are written to the result queue at
// the clock edge that accepts it and can be taken the next cycle
// a byte that closes one token and emits another puts two tokens in the queue,
// so sustained rate is one byte per cycle as long as bytes give at most one token each
// in_chan.ready is low while fewer than two queue slots are free
// rst_n is synchronous and clears lexer state and the queue
module keyword_token_lexer (
  input  logic       clk,
  input  logic       rst_n,
  ktl_in_if.sink     in_chan,
  ktl_out_if.source  out_chan
);
  import ktl_pkg::*;

  // lexer state
  logic [MODE_W-1:0]   mode_r,   mode_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [LEN_W-1:0]    len_r,    len_nxt;
  logic [POS_W-1:0]    start_r,  start_nxt;
  logic [POS_W-1:0]    pos_r,    pos_nxt;
  logic                ovf_r,    ovf_nxt;

  // result queue
  tok_t                queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head_r, tail_r;
  logic [QCNT_W-1:0]   count_r;

  logic                in_acc, out_acc;
  logic [CHAR_W-1:0]   c;
  logic                grows, pair;
  logic [KIND_W-1:0]   word_kind, pair_kind;
  tok_t                flush_tok, tok_a, tok_b, wr0, wr1;
  logic                a_vld, b_vld;
  logic [1:0]          push_n;

  assign c       = in_chan.char_code;
  assign in_chan.ready = count_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // keyword match on the held prefix
  always_comb begin
    word_kind = K_IDENT;
    if (!ovf_r) begin
      priority if (len_r == LEN_W'(2) && prefix_r == PACK_IF)    word_kind = K_IF;
      else if (len_r == LEN_W'(4) && prefix_r == PACK_ELSE)      word_kind = K_ELSE;
      else if (len_r == LEN_W'(5) && prefix_r == PACK_WHILE)     word_kind = K_WHILE;
      else if (len_r == LEN_W'(3) && prefix_r == PACK_LTD)       word_kind = K_LTD;
      else                                                       word_kind = K_IDENT;
    end
  end

  // pending token as closed by a byte that cannot extend it
  always_comb begin
    flush_tok       = '0;
    flush_tok.start = start_r;
    flush_tok.length = LEN_W'(1);
    pair_kind       = K_GEQ;
    unique case (mode_r)
      MODE_WORD: begin
        flush_tok.kind   = word_kind;
        flush_tok.length = len_r;
        flush_tok.sat    = ovf_r;
      end
      MODE_NUM: begin
        flush_tok.kind   = K_NUMBER;
        flush_tok.length = len_r;
        flush_tok.sat    = ovf_r;
      end
      MODE_EQ: begin
        flush_tok.kind = K_INVALID;
        pair_kind      = K_EQ;
      end
      MODE_BANG: begin
        flush_tok.kind = K_INVALID;
        pair_kind      = K_NEQ;
      end
      MODE_LT: begin
        flush_tok.kind = K_LT;
        pair_kind      = K_LEQ;
      end
      MODE_GT: begin
        flush_tok.kind = K_GT;
        pair_kind      = K_GEQ;
      end
      default: flush_tok.kind = K_INVALID;
    endcase
  end

  assign grows = (mode_r == MODE_WORD && (is_alpha(c) || is_numeral(c))) ||
                 (mode_r == MODE_NUM && is_numeral(c));
  assign pair  = (mode_r == MODE_EQ || mode_r == MODE_BANG ||
                  mode_r == MODE_LT || mode_r == MODE_GT) && c == CH_EQUAL;

  // per-byte lexing step
  always_comb begin
    mode_nxt   = mode_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    a_vld      = 1'b0;
    b_vld      = 1'b0;
    tok_a      = flush_tok;
    tok_b      = '0;
    if (in_acc) begin
      pos_nxt = pos_r + 1'b1;
      if (c == CH_NUL) begin
        // end of text: flush, emit END, back to reset values
        a_vld       = mode_r != MODE_IDLE;
        b_vld       = 1'b1;
        tok_b.kind  = K_END;
        tok_b.start = pos_r;
        mode_nxt    = MODE_IDLE;
        prefix_nxt  = '0;
        len_nxt     = '0;
        start_nxt   = '0;
        pos_nxt     = '0;
        ovf_nxt     = 1'b0;
      end else if (grows) begin
        // grow the current word or number
        unique case (len_r)
          LEN_W'(1): prefix_nxt[15:8]  = c;
          LEN_W'(2): prefix_nxt[23:16] = c;
          LEN_W'(3): prefix_nxt[31:24] = c;
          LEN_W'(4): prefix_nxt[39:32] = c;
          default:   prefix_nxt = prefix_r;
        endcase
        if (len_r < LEN_W'(MAX_LEXEME)) len_nxt = len_r + 1'b1;
        else                            ovf_nxt = 1'b1;
      end else if (pair) begin
        // two-character relational operator
        b_vld        = 1'b1;
        tok_b.kind   = pair_kind;
        tok_b.start  = start_r;
        tok_b.length = LEN_W'(2);
        mode_nxt     = MODE_IDLE;
      end else begin
        // close any pending token, then lex the byte from idle
        a_vld    = mode_r != MODE_IDLE;
        mode_nxt = MODE_IDLE;
        if (open_mode(c) != MODE_IDLE) begin
          mode_nxt   = open_mode(c);
          prefix_nxt = {{(PREFIX_W-CHAR_W){1'b0}}, c};
          len_nxt    = LEN_W'(1);
          start_nxt  = pos_r;
          ovf_nxt    = 1'b0;
        end else if (!is_space(c)) begin
          b_vld        = 1'b1;
          tok_b.kind   = single_kind(c);
          tok_b.start  = pos_r;
          tok_b.length = LEN_W'(1);
        end
      end
    end
    tok_b.last = 1'b1;
    tok_a.last = !b_vld;
  end

  // compact the tokens onto the queue tail
  assign wr0    = a_vld ? tok_a : tok_b;
  assign wr1    = tok_b;
  assign push_n = {1'b0, a_vld} + {1'b0, b_vld};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      prefix_r <= '0;
      len_r    <= '0;
      start_r  <= '0;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
      start_r  <= start_nxt;
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (out_acc) head_r <= head_r + 1'b1;
      tail_r  <= tail_r + QPTR_W'(push_n);
      count_r <= count_r + QCNT_W'(push_n) - QCNT_W'(out_acc);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue_r[tail_r] <= wr0;
    if (push_n == 2'd2) queue_r[QPTR_W'(tail_r + 1'b1)] <= wr1;
  end

  // result channel
  assign out_chan.valid            = count_r != '0;
  assign out_chan.token_kind       = queue_r[head_r].kind;
  assign out_chan.token_start      = queue_r[head_r].start;
  assign out_chan.token_length     = queue_r[head_r].length;
  assign out_chan.length_saturated = queue_r[head_r].sat;
  assign out_chan.last_of_run      = queue_r[head_r].last;

  // queue never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue over capacity");

  // a byte is only taken with room for two tokens
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> count_r <= QCNT_W'(QUEUE_DEPTH - 2))
    else $error("byte accepted without queue room");

  // end of text returns the lexer to its reset state
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && c == CH_NUL) |=> (mode_r == MODE_IDLE && pos_r == '0 && len_r == '0))
    else $error("lexer state not cleared after end of text");

  // overflow only once the length has stuck at its limit
  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == LEN_W'(MAX_LEXEME))
    else $error("length overflow below limit");

  // every accepted byte that pushes a token leaves the output valid next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && push_n != 2'd0) |=> out_chan.valid)
    else $error("pushed token not visible");

endmodule
